@@ rtl/rcc_pkg.sv @@
// shared types, constants and request codes of the rgb/cmyk converter
package rcc_pkg;

  // channel and percentage formats
  localparam int CHANNEL_BITS = 8;
  localparam int CH_MAX       = (1 << CHANNEL_BITS) - 1;
  localparam int PCT_BITS     = 14;
  localparam int FULL_SCALE   = 10000;
  localparam longint unsigned FULL_SCALE_SQ = 64'd100000000;

  // rounded division by the max channel: exact ceiling reciprocal
  localparam int NUM_BITS   = $clog2(FULL_SCALE * CH_MAX + CH_MAX / 2 + 1);
  localparam int SHIFT      = NUM_BITS + CHANNEL_BITS;
  localparam int RECIP_BITS = SHIFT + 1;
  localparam longint unsigned RECIP_MAX = ((64'd1 << SHIFT) + CH_MAX - 1) / CH_MAX;

  // floor division by full scale squared: floor reciprocal plus one correction
  localparam int AB_BITS = $clog2(FULL_SCALE_SQ + 1);
  localparam int P_BITS  = $clog2(FULL_SCALE_SQ * CH_MAX + 1);
  localparam longint unsigned K_RECIP = (64'd1 << P_BITS) / FULL_SCALE_SQ;
  localparam int K_RECIP_BITS = $clog2(K_RECIP + 1);

  // register stages inside every lane
  localparam int LANE_STAGES = 4;

  // conversion direction codes
  localparam logic REQ_RGB2CMYK = 1'b0;
  localparam logic REQ_CMYK2RGB = 1'b1;

  // request word
  typedef struct packed {
    logic                    req_type;
    logic [CHANNEL_BITS-1:0] in_red;
    logic [CHANNEL_BITS-1:0] in_green;
    logic [CHANNEL_BITS-1:0] in_blue;
    logic [PCT_BITS-1:0]     in_cyan;
    logic [PCT_BITS-1:0]     in_magenta;
    logic [PCT_BITS-1:0]     in_yellow;
    logic [PCT_BITS-1:0]     in_black;
  } in_t;

  // result word
  typedef struct packed {
    logic [CHANNEL_BITS-1:0] out_red;
    logic [CHANNEL_BITS-1:0] out_green;
    logic [CHANNEL_BITS-1:0] out_blue;
    logic [PCT_BITS-1:0]     out_cyan;
    logic [PCT_BITS-1:0]     out_magenta;
    logic [PCT_BITS-1:0]     out_yellow;
    logic [PCT_BITS-1:0]     out_black;
  } out_t;

  // pass-through fields that ride beside the lanes
  typedef struct packed {
    logic                    req_type;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    logic [PCT_BITS-1:0]     cyan;
    logic [PCT_BITS-1:0]     magenta;
    logic [PCT_BITS-1:0]     yellow;
    logic [PCT_BITS-1:0]     black;
  } side_t;

  // front stage word handed to the lanes
  typedef struct packed {
    side_t                   side;
    logic [CHANNEL_BITS-1:0] mx;
    logic [RECIP_BITS-1:0]   recip;
  } front_t;

endpackage

@@ rtl/rcc_front.sv @@
// input stage: cmyk saturation, max channel and reciprocal lookup
module rcc_front (
  input  logic           clk_i,
  input  rcc_pkg::in_t   in_i,
  output rcc_pkg::front_t front_o
);

  logic [rcc_pkg::RECIP_BITS-1:0] recip_tbl [rcc_pkg::CH_MAX+1];
  logic [rcc_pkg::CHANNEL_BITS-1:0] mx_d;
  rcc_pkg::front_t front_d;
  rcc_pkg::front_t front_q;

  // clamp a percentage to full scale
  function automatic logic [rcc_pkg::PCT_BITS-1:0] sat_pct(
    input logic [rcc_pkg::PCT_BITS-1:0] v
  );
    logic [rcc_pkg::PCT_BITS-1:0] fs;
    fs = rcc_pkg::PCT_BITS'(rcc_pkg::FULL_SCALE);
    return (v > fs) ? fs : v;
  endfunction

  // ceiling reciprocal table, zero for a black pixel
  assign recip_tbl[0] = '0;
  for (genvar gi = 1; gi <= rcc_pkg::CH_MAX; gi++) begin : g_recip
    localparam longint unsigned RV = ((64'd1 << rcc_pkg::SHIFT) + gi - 1) / gi;
    assign recip_tbl[gi] = rcc_pkg::RECIP_BITS'(RV);
  end

  // largest of the three channels
  always_comb begin
    mx_d = in_i.in_red;
    if (in_i.in_green > mx_d) begin
      mx_d = in_i.in_green;
    end
    if (in_i.in_blue > mx_d) begin
      mx_d = in_i.in_blue;
    end
  end

  // assemble the front word
  always_comb begin
    front_d.side.req_type = in_i.req_type;
    front_d.side.red      = in_i.in_red;
    front_d.side.green    = in_i.in_green;
    front_d.side.blue     = in_i.in_blue;
    front_d.side.cyan     = sat_pct(in_i.in_cyan);
    front_d.side.magenta  = sat_pct(in_i.in_magenta);
    front_d.side.yellow   = sat_pct(in_i.in_yellow);
    front_d.side.black    = sat_pct(in_i.in_black);
    front_d.mx            = mx_d;
    front_d.recip         = recip_tbl[mx_d];
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
  end

  assign front_o = front_q;

endmodule

@@ rtl/rcc_div_lane.sv @@
// lane for round(10000 * (den - chan) / den) by reciprocal multiply
module rcc_div_lane (
  input  logic                               clk_i,
  input  logic [rcc_pkg::CHANNEL_BITS-1:0]   chan_i,
  input  logic [rcc_pkg::CHANNEL_BITS-1:0]   den_i,
  input  logic [rcc_pkg::RECIP_BITS-1:0]     recip_i,
  output logic [rcc_pkg::PCT_BITS-1:0]       pct_o
);

  localparam int ProdBits = rcc_pkg::NUM_BITS + rcc_pkg::RECIP_BITS;

  logic [rcc_pkg::CHANNEL_BITS-1:0] diff;
  logic [rcc_pkg::NUM_BITS-1:0]     num_d;
  logic [rcc_pkg::NUM_BITS-1:0]     num_q;
  logic [rcc_pkg::RECIP_BITS-1:0]   recip_q;
  logic [ProdBits-1:0]              prod_q;
  logic [rcc_pkg::PCT_BITS-1:0]     quo_q;
  logic [rcc_pkg::PCT_BITS-1:0]     pct_q;

  // scaled numerator with half the divisor for round half up
  assign diff  = den_i - chan_i;
  assign num_d = rcc_pkg::NUM_BITS'(rcc_pkg::FULL_SCALE * int'(diff) + int'(den_i >> 1));

  // numerator, product, quotient, then one stage to line up with the rgb lanes
  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    recip_q <= recip_i;
    prod_q  <= ProdBits'(num_q) * ProdBits'(recip_q);
    quo_q   <= prod_q[rcc_pkg::SHIFT +: rcc_pkg::PCT_BITS];
    pct_q   <= quo_q;
  end

  assign pct_o = pct_q;

endmodule

@@ rtl/rcc_mul_lane.sv @@
// lane for floor(255 * (10000 - colour) * (10000 - black) / 10^8)
module rcc_mul_lane (
  input  logic                             clk_i,
  input  logic [rcc_pkg::PCT_BITS-1:0]     colour_i,
  input  logic [rcc_pkg::PCT_BITS-1:0]     black_i,
  output logic [rcc_pkg::CHANNEL_BITS-1:0] chan_o
);

  localparam int TBits = rcc_pkg::P_BITS + rcc_pkg::K_RECIP_BITS;

  logic [rcc_pkg::PCT_BITS-1:0]     inv_c;
  logic [rcc_pkg::PCT_BITS-1:0]     inv_k;
  logic [rcc_pkg::AB_BITS-1:0]      ab_q;
  logic [rcc_pkg::P_BITS-1:0]       pm_q;
  logic [rcc_pkg::P_BITS-1:0]       pm_dly_q;
  logic [TBits-1:0]                 t_q;
  logic [rcc_pkg::CHANNEL_BITS-1:0] q0;
  logic [rcc_pkg::P_BITS-1:0]       rem;
  logic [rcc_pkg::CHANNEL_BITS-1:0] chan_d;
  logic [rcc_pkg::CHANNEL_BITS-1:0] chan_q;

  // complements against full scale
  assign inv_c = rcc_pkg::PCT_BITS'(rcc_pkg::FULL_SCALE) - colour_i;
  assign inv_k = rcc_pkg::PCT_BITS'(rcc_pkg::FULL_SCALE) - black_i;

  // estimate may be one low: fix it with the remainder
  assign q0     = t_q[rcc_pkg::P_BITS +: rcc_pkg::CHANNEL_BITS];
  assign rem    = pm_dly_q - rcc_pkg::P_BITS'(64'(q0) * rcc_pkg::FULL_SCALE_SQ);
  assign chan_d = (rem >= rcc_pkg::P_BITS'(rcc_pkg::FULL_SCALE_SQ)) ? q0 + 1'b1 : q0;

  // product, scale by channel max, reciprocal multiply, correction
  always_ff @(posedge clk_i) begin
    ab_q     <= rcc_pkg::AB_BITS'(inv_c) * rcc_pkg::AB_BITS'(inv_k);
    pm_q     <= rcc_pkg::P_BITS'(ab_q) * rcc_pkg::P_BITS'(rcc_pkg::CH_MAX);
    t_q      <= TBits'(pm_q) * TBits'(rcc_pkg::K_RECIP);
    pm_dly_q <= pm_q;
    chan_q   <= chan_d;
  end

  assign chan_o = chan_q;

endmodule

@@ rtl/rcc_merge.sv @@
// merge stage: picks computed or passed-through fields and drives the result
module rcc_merge (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  rcc_pkg::side_t side_i,
  input  rcc_pkg::out_t  calc_i,
  output logic           res_valid_o,
  output rcc_pkg::out_t  res_o
);

  rcc_pkg::out_t res_d;
  rcc_pkg::out_t res_q;
  logic          res_valid_q;

  // direction selects which half is computed
  always_comb begin
    res_d = calc_i;
    case (side_i.req_type)
      rcc_pkg::REQ_RGB2CMYK: begin
        res_d.out_red   = side_i.red;
        res_d.out_green = side_i.green;
        res_d.out_blue  = side_i.blue;
      end
      rcc_pkg::REQ_CMYK2RGB: begin
        res_d.out_cyan    = side_i.cyan;
        res_d.out_magenta = side_i.magenta;
        res_d.out_yellow  = side_i.yellow;
        res_d.out_black   = side_i.black;
      end
      default: begin
        res_d = calc_i;
      end
    endcase
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= valid_i;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/rgb_cmyk_converter_top.sv @@
// rgb/cmyk converter: one word per clock, busy is never raised.
// the result strobe follows the accepted word through the front stage, four lane
// stages and the output register.
// throughput: one word per cycle, set by the fully pipelined lane multipliers.
// reset clears the valid pipeline and the strobe; data registers are not reset.
// the receiver cannot stall: each result stands for exactly one cycle.
module rgb_cmyk_converter_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rcc_pkg::in_t  req_i,
  output logic          res_valid_o,
  output rcc_pkg::out_t res_o
);

  localparam int Ls = rcc_pkg::LANE_STAGES;

  rcc_pkg::front_t front;
  rcc_pkg::side_t  side_q [Ls];
  rcc_pkg::out_t   calc;
  logic [Ls:0]     vld_q;
  logic            accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // input stage
  rcc_front u_front (
    .clk_i   (clk_i),
    .in_i    (req_i),
    .front_o (front)
  );

  // cyan, magenta, yellow lanes divide by the max channel
  rcc_div_lane u_div_c (
    .clk_i   (clk_i),
    .chan_i  (front.side.red),
    .den_i   (front.mx),
    .recip_i (front.recip),
    .pct_o   (calc.out_cyan)
  );

  rcc_div_lane u_div_m (
    .clk_i   (clk_i),
    .chan_i  (front.side.green),
    .den_i   (front.mx),
    .recip_i (front.recip),
    .pct_o   (calc.out_magenta)
  );

  rcc_div_lane u_div_y (
    .clk_i   (clk_i),
    .chan_i  (front.side.blue),
    .den_i   (front.mx),
    .recip_i (front.recip),
    .pct_o   (calc.out_yellow)
  );

  // black lane divides by the channel max
  rcc_div_lane u_div_k (
    .clk_i   (clk_i),
    .chan_i  (front.mx),
    .den_i   (rcc_pkg::CHANNEL_BITS'(rcc_pkg::CH_MAX)),
    .recip_i (rcc_pkg::RECIP_BITS'(rcc_pkg::RECIP_MAX)),
    .pct_o   (calc.out_black)
  );

  // red, green, blue lanes
  rcc_mul_lane u_mul_r (
    .clk_i    (clk_i),
    .colour_i (front.side.cyan),
    .black_i  (front.side.black),
    .chan_o   (calc.out_red)
  );

  rcc_mul_lane u_mul_g (
    .clk_i    (clk_i),
    .colour_i (front.side.magenta),
    .black_i  (front.side.black),
    .chan_o   (calc.out_green)
  );

  rcc_mul_lane u_mul_b (
    .clk_i    (clk_i),
    .colour_i (front.side.yellow),
    .black_i  (front.side.black),
    .chan_o   (calc.out_blue)
  );

  // valid pipeline alongside front and lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Ls-1:0], accept};
    end
  end

  // pass-through fields delayed to the lane outputs
  always_ff @(posedge clk_i) begin
    side_q[0] <= front.side;
    for (int i = 1; i < Ls; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // output selection and register
  rcc_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (vld_q[Ls]),
    .side_i      (side_q[Ls-1]),
    .calc_i      (calc),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

@@ rtl/rcc_checker.sv @@
// port-level checks of the rgb/cmyk converter and their binding
module rcc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input rcc_pkg::in_t  req_i,
  input logic          res_valid_o,
  input rcc_pkg::out_t res_o
);

  localparam logic [rcc_pkg::PCT_BITS-1:0] Fs = rcc_pkg::PCT_BITS'(rcc_pkg::FULL_SCALE);

  // the converter never holds off a word
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

  // a result strobe is seen only for an earlier accepted word
  a_strobe_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start && !busy, 6))
    else $error("result strobe without matching request");

  // cmyk results stay within full scale
  a_cmyk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.out_cyan <= Fs && res_o.out_magenta <= Fs &&
                     res_o.out_yellow <= Fs && res_o.out_black <= Fs))
    else $error("cmyk result above full scale");

  // rgb to cmyk passes the channels through
  a_rgb_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.req_type == rcc_pkg::REQ_RGB2CMYK) |->
      ##6 (res_valid_o && res_o.out_red == $past(req_i.in_red, 6) &&
           res_o.out_green == $past(req_i.in_green, 6) &&
           res_o.out_blue == $past(req_i.in_blue, 6)))
    else $error("rgb pass-through mismatch");

  // full black key gives a black pixel
  a_full_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.req_type == rcc_pkg::REQ_CMYK2RGB && req_i.in_black >= Fs) |->
      ##6 (res_o.out_red == '0 && res_o.out_green == '0 && res_o.out_blue == '0 &&
           res_o.out_black == Fs))
    else $error("full black key did not give black");

endmodule

bind rgb_cmyk_converter_top rcc_checker u_rcc_checker (.*);
